>>> rtl/adc_pkg.sv
package adc_pkg;

    // time and address widths
    localparam int TIME_W = 32;
    localparam int ADDR_W = 5;
    localparam int REG_IDX_W = 3;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_CLOSED_ANGLE  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_OPEN_ANGLE    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PRESENCE_THR  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_HOLD_OPEN     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_STEP_PERIOD   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SENSOR_PERIOD = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE      = 3'd6;

    // register reset values
    localparam logic [7:0]  RST_CLOSED_ANGLE  = 8'd10;
    localparam logic [7:0]  RST_OPEN_ANGLE    = 8'd170;
    localparam logic [11:0] RST_PRESENCE_THR  = 12'd80;
    localparam logic [15:0] RST_HOLD_OPEN     = 16'd10000;
    localparam logic [7:0]  RST_STEP_PERIOD   = 8'd20;
    localparam logic [9:0]  RST_SENSOR_PERIOD = 10'd100;
    localparam logic [9:0]  RST_DEBOUNCE      = 10'd200;

    // door states
    localparam logic [1:0] DOOR_CLOSED  = 2'd0;
    localparam logic [1:0] DOOR_OPENING = 2'd1;
    localparam logic [1:0] DOOR_OPEN    = 2'd2;
    localparam logic [1:0] DOOR_CLOSING = 2'd3;

    localparam logic [7:0] ANGLE_MAX = 8'd255;

    typedef struct packed {
        logic [7:0]  closed_angle;
        logic [7:0]  open_angle;
        logic [11:0] presence_threshold_mm;
        logic [15:0] hold_open_ms;
        logic [7:0]  step_period_ms;
        logic [9:0]  sensor_period_ms;
        logic [9:0]  press_guard_ms;
    } t_cfg;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        button_level;
        logic [11:0] distance_mm;
        logic        emergency;
    } t_item;

    typedef struct packed {
        logic [1:0]  door_state;
        logic [7:0]  angle_out;
        logic        servo_enable;
        logic        angle_written;
        logic        sensor_sampled;
        logic [15:0] client_count;
    } t_result;

    // wrapping time difference
    function automatic logic [TIME_W-1:0] elapsed(input logic [TIME_W-1:0] now_t,
                                                  input logic [TIME_W-1:0] then_t);
        return now_t - then_t;
    endfunction

endpackage

>>> rtl/adc_if.sv
interface adc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic        button_level;
    logic [11:0] distance_mm;
    logic        emergency;

    modport source (output valid, output now_ms, output button_level,
                    output distance_mm, output emergency, input ready);
    modport sink (input valid, input now_ms, input button_level,
                  input distance_mm, input emergency, output ready);
endinterface

interface adc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  door_state;
    logic [7:0]  angle_out;
    logic        servo_enable;
    logic        angle_written;
    logic        sensor_sampled;
    logic [15:0] client_count;

    modport source (output valid, output door_state, output angle_out,
                    output servo_enable, output angle_written, output sensor_sampled,
                    output client_count, input ready);
    modport sink (input valid, input door_state, input angle_out,
                  input servo_enable, input angle_written, input sensor_sampled,
                  input client_count, output ready);
endinterface

>>> rtl/adc_cfg_regs.sv
module adc_cfg_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [adc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output adc_pkg::t_cfg             o_cfg
);
    import adc_pkg::*;

    t_cfg                 r_cfg;
    logic                 w_wr;
    logic [REG_IDX_W-1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[ADDR_W-1:2];
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.closed_angle          <= RST_CLOSED_ANGLE;
            r_cfg.open_angle            <= RST_OPEN_ANGLE;
            r_cfg.presence_threshold_mm <= RST_PRESENCE_THR;
            r_cfg.hold_open_ms          <= RST_HOLD_OPEN;
            r_cfg.step_period_ms        <= RST_STEP_PERIOD;
            r_cfg.sensor_period_ms      <= RST_SENSOR_PERIOD;
            r_cfg.press_guard_ms        <= RST_DEBOUNCE;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_CLOSED_ANGLE:  r_cfg.closed_angle          <= pwdata[7:0];
                REG_OPEN_ANGLE:    r_cfg.open_angle            <= pwdata[7:0];
                REG_PRESENCE_THR:  r_cfg.presence_threshold_mm <= pwdata[11:0];
                REG_HOLD_OPEN:     r_cfg.hold_open_ms          <= pwdata[15:0];
                REG_STEP_PERIOD:   r_cfg.step_period_ms        <= pwdata[7:0];
                REG_SENSOR_PERIOD: r_cfg.sensor_period_ms      <= pwdata[9:0];
                REG_DEBOUNCE:      r_cfg.press_guard_ms        <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (w_idx)
            REG_CLOSED_ANGLE:  prdata = {24'd0, r_cfg.closed_angle};
            REG_OPEN_ANGLE:    prdata = {24'd0, r_cfg.open_angle};
            REG_PRESENCE_THR:  prdata = {20'd0, r_cfg.presence_threshold_mm};
            REG_HOLD_OPEN:     prdata = {16'd0, r_cfg.hold_open_ms};
            REG_STEP_PERIOD:   prdata = {24'd0, r_cfg.step_period_ms};
            REG_SENSOR_PERIOD: prdata = {22'd0, r_cfg.sensor_period_ms};
            REG_DEBOUNCE:      prdata = {22'd0, r_cfg.press_guard_ms};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

>>> rtl/automatic_door_controller_unit.sv
// Automatic door controller: one time sample per transaction in, one status
// transaction out. A sample is captured in an input register; when the output
// is not stalled, the door sequencer (closed, opening, open, closing) updates
// its state from it and loads the result register, so a new sample can be
// taken every cycle while the output is not stalled. The rate is set by the
// state update loop and the result register: one sample per cycle when the
// output is not stalled. The user must write registers over the APB port only
// while no sample is in flight; the block itself does not enforce this.
module automatic_door_controller_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    adc_in_if.sink                     i_in,
    adc_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [adc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import adc_pkg::*;

    t_cfg    w_cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    logic    w_adv;
    logic    w_proc;

    // sequencer state
    logic [1:0]        r_mode,        n_mode;
    logic [7:0]        r_angle,       n_angle;
    logic              r_attached,    n_attached;
    logic              r_emer_held,   n_emer_held;
    logic              r_last_btn,    n_last_btn;
    logic [TIME_W-1:0] r_press_t,     n_press_t;
    logic [TIME_W-1:0] r_move_t,      n_move_t;
    logic [TIME_W-1:0] r_open_since,  n_open_since;
    logic [TIME_W-1:0] r_closed_smp,  n_closed_smp;
    logic [TIME_W-1:0] r_closing_smp, n_closing_smp;
    logic [15:0]       r_tally,       n_tally;
    t_result           n_out;

    logic [TIME_W-1:0] w_now;
    logic              w_present;
    logic              w_start;
    logic              w_wrote;
    logic              w_sampled;
    logic              w_reversed;

    adc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // pipeline flow control
    assign w_adv       = !r_out_valid || o_out.ready;
    assign w_proc      = r_in_valid && w_adv;
    assign i_in.ready  = !r_in_valid || w_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.now_ms       <= i_in.now_ms;
            r_in.button_level <= i_in.button_level;
            r_in.distance_mm  <= i_in.distance_mm;
            r_in.emergency    <= i_in.emergency;
        end
    end

    assign w_now     = TIME_W'(r_in.now_ms);
    assign w_present = (r_in.distance_mm != 12'd0) &&
                       (r_in.distance_mm < w_cfg.presence_threshold_mm);

    // door sequencer next state
    always_comb begin
        n_mode        = r_mode;
        n_angle       = r_angle;
        n_attached    = r_attached;
        n_emer_held   = r_emer_held;
        n_last_btn    = r_last_btn;
        n_press_t     = r_press_t;
        n_move_t      = r_move_t;
        n_open_since  = r_open_since;
        n_closed_smp  = r_closed_smp;
        n_closing_smp = r_closing_smp;
        w_start       = 1'b0;
        w_wrote       = 1'b0;
        w_sampled     = 1'b0;
        w_reversed    = 1'b0;

        if (r_in.emergency) begin
            n_emer_held = 1'b1;
            n_attached  = 1'b0;
        end else begin
            // leaving emergency forces closing
            if (r_emer_held) begin
                n_emer_held = 1'b0;
                n_attached  = 1'b1;
                n_mode      = DOOR_CLOSING;
            end

            // debounced falling edge of the button
            if (!r_in.button_level && r_last_btn &&
                (elapsed(w_now, r_press_t) > TIME_W'(w_cfg.press_guard_ms))) begin
                n_press_t = w_now;
                if (n_mode == DOOR_CLOSED || n_mode == DOOR_CLOSING) begin
                    w_start    = 1'b1;
                    n_attached = 1'b1;
                    n_mode     = DOOR_OPENING;
                end
            end
            n_last_btn = r_in.button_level;

            unique case (n_mode)
                DOOR_CLOSED: begin
                    if (elapsed(w_now, r_closed_smp) >= TIME_W'(w_cfg.sensor_period_ms)) begin
                        n_closed_smp = w_now;
                        w_sampled    = 1'b1;
                        if (w_present) begin
                            w_start    = 1'b1;
                            n_attached = 1'b1;
                            n_mode     = DOOR_OPENING;
                        end
                    end
                end
                DOOR_OPENING: begin
                    if (elapsed(w_now, r_move_t) >= TIME_W'(w_cfg.step_period_ms)) begin
                        n_move_t = w_now;
                        if (r_angle != ANGLE_MAX) begin
                            n_angle = r_angle + 8'd1;
                        end
                        w_wrote = 1'b1;
                        if (n_angle >= w_cfg.open_angle) begin
                            n_open_since = w_now;
                            n_mode       = DOOR_OPEN;
                        end
                    end
                end
                DOOR_OPEN: begin
                    if (elapsed(w_now, r_open_since) >= TIME_W'(w_cfg.hold_open_ms)) begin
                        n_mode = DOOR_CLOSING;
                    end
                end
                DOOR_CLOSING: begin
                    if (elapsed(w_now, r_closing_smp) >=
                        TIME_W'(w_cfg.sensor_period_ms)) begin
                        n_closing_smp = w_now;
                        w_sampled     = 1'b1;
                        if (w_present) begin
                            w_start    = 1'b1;
                            w_reversed = 1'b1;
                            n_attached = 1'b1;
                            n_mode     = DOOR_OPENING;
                        end
                    end
                    if (!w_reversed &&
                        (elapsed(w_now, r_move_t) >= TIME_W'(w_cfg.step_period_ms))) begin
                        n_move_t = w_now;
                        if (r_angle != 8'd0) begin
                            n_angle = r_angle - 8'd1;
                        end
                        w_wrote = 1'b1;
                        if (n_angle <= w_cfg.closed_angle) begin
                            n_attached = 1'b0;
                            n_mode     = DOOR_CLOSED;
                        end
                    end
                end
                default: ;
            endcase
        end

        // at most one opening per sample
        n_tally = w_start ? r_tally + 16'd1 : r_tally;

        n_out.door_state     = n_mode;
        n_out.angle_out      = n_angle;
        n_out.servo_enable   = n_attached;
        n_out.angle_written  = w_wrote;
        n_out.sensor_sampled = w_sampled;
        n_out.client_count   = n_tally;
    end

    // sequencer state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= DOOR_CLOSED;
            r_angle       <= RST_CLOSED_ANGLE;
            r_attached    <= 1'b0;
            r_emer_held   <= 1'b0;
            r_last_btn    <= 1'b1;
            r_press_t     <= '0;
            r_move_t      <= '0;
            r_open_since  <= '0;
            r_closed_smp  <= '0;
            r_closing_smp <= '0;
            r_tally       <= 16'd0;
        end else if (w_proc) begin
            r_mode        <= n_mode;
            r_angle       <= n_angle;
            r_attached    <= n_attached;
            r_emer_held   <= n_emer_held;
            r_last_btn    <= n_last_btn;
            r_press_t     <= n_press_t;
            r_move_t      <= n_move_t;
            r_open_since  <= n_open_since;
            r_closed_smp  <= n_closed_smp;
            r_closing_smp <= n_closing_smp;
            r_tally       <= n_tally;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.door_state     = r_out.door_state;
    assign o_out.angle_out      = r_out.angle_out;
    assign o_out.servo_enable   = r_out.servo_enable;
    assign o_out.angle_written  = r_out.angle_written;
    assign o_out.sensor_sampled = r_out.sensor_sampled;
    assign o_out.client_count   = r_out.client_count;

    // the client count only ever advances by one
    a_tally_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tally != $past(r_tally)) |-> (r_tally == $past(r_tally) + 16'd1))
        else $error("client count jumped");

    // the angle only moves when a sample is processed
    a_angle_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_proc |=> $stable(r_angle))
        else $error("angle moved without a sample");

    // emergency keeps the servo released
    a_emer_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emer_held |-> !r_attached)
        else $error("servo attached during emergency");

    // a servo step happens with the drive attached, unless it just closed the door
    a_step_attached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.angle_written) |->
        (r_out.servo_enable || (r_out.door_state == DOOR_CLOSED)))
        else $error("servo stepped while released");

    // the sensor is never sampled while the door is open
    a_sample_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.sensor_sampled) |-> (r_out.door_state != DOOR_OPEN))
        else $error("sensor sampled while open");

endmodule

>>> verif/automatic_door_controller_unit_tb.sv
`timescale 1ns / 100ps

module automatic_door_controller_unit_tb;
    import adc_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // apb configuration port
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    adc_in_if  in_ch ();
    adc_out_if out_ch ();

    automatic_door_controller_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    typedef struct {
        t_item smp;
        logic  drain_first;
    } t_pending;

    t_pending    sample_q[$];
    t_result     status_exp_q[$];
    int          fail_count = 0;

    // handshake pacing
    int unsigned in_gap = 0;
    int unsigned out_wait = 0;
    logic        in_calm = 1'b0;
    logic        out_calm = 1'b0;

    // stimulus generator state
    logic [31:0] g_now;
    logic        g_btn;
    int unsigned g_emer_left;

    // door predictor: configuration copy and sequencer state
    t_cfg        cfg;
    logic [1:0]  d_mode;
    logic [7:0]  d_angle;
    logic        d_attached;
    logic        d_emer_held;
    logic        d_last_btn;
    logic [31:0] d_press_t;
    logic [31:0] d_move_t;
    logic [31:0] d_open_t;
    logic [31:0] d_closed_smp_t;
    logic [31:0] d_closing_smp_t;
    logic [15:0] d_clients;

    task automatic report_err(input string what, input int unsigned got,
                              input int unsigned want);
        fail_count++;
        $display("mismatch on %s at %0t: got %0d, expected %0d", what, $time, got, want);
    endtask

    function automatic t_cfg cfg_of(input int unsigned ca, input int unsigned oa,
                                    input int unsigned thr, input int unsigned hold,
                                    input int unsigned stp, input int unsigned sen,
                                    input int unsigned deb);
        t_cfg c;
        c.closed_angle          = ca[7:0];
        c.open_angle            = oa[7:0];
        c.presence_threshold_mm = thr[11:0];
        c.hold_open_ms          = hold[15:0];
        c.step_period_ms        = stp[7:0];
        c.sensor_period_ms      = sen[9:0];
        c.press_guard_ms        = deb[9:0];
        return c;
    endfunction

    // wrapping time difference
    function automatic logic [31:0] ms_since(input logic [31:0] now_t,
                                             input logic [31:0] then_t);
        return now_t - then_t;
    endfunction

    function automatic logic someone_there(input logic [11:0] range_mm);
        return range_mm != 12'd0 && range_mm < cfg.presence_threshold_mm;
    endfunction

    task automatic open_door();
        d_attached = 1'b1;
        d_mode     = DOOR_OPENING;
        d_clients  = d_clients + 16'd1;
    endtask

    // one time sample through the door sequencer, queues the expected status
    task automatic advance_door(input t_item it);
        logic    wrote;
        logic    sampled;
        logic    turned;
        t_result res;
        wrote   = 1'b0;
        sampled = 1'b0;
        turned  = 1'b0;
        if (it.emergency) begin
            d_emer_held = 1'b1;
            d_attached  = 1'b0;
        end else begin
            // leaving emergency forces a close
            if (d_emer_held) begin
                d_emer_held = 1'b0;
                d_attached  = 1'b1;
                d_mode      = DOOR_CLOSING;
            end
            // debounced press
            if (!it.button_level && d_last_btn &&
                ms_since(it.now_ms, d_press_t) > cfg.press_guard_ms) begin
                d_press_t = it.now_ms;
                if (d_mode == DOOR_CLOSED || d_mode == DOOR_CLOSING)
                    open_door();
            end
            d_last_btn = it.button_level;
            case (d_mode)
                DOOR_CLOSED: begin
                    if (ms_since(it.now_ms, d_closed_smp_t) >= cfg.sensor_period_ms) begin
                        d_closed_smp_t = it.now_ms;
                        sampled        = 1'b1;
                        if (someone_there(it.distance_mm))
                            open_door();
                    end
                end
                DOOR_OPENING: begin
                    if (ms_since(it.now_ms, d_move_t) >= cfg.step_period_ms) begin
                        d_move_t = it.now_ms;
                        if (d_angle != ANGLE_MAX)
                            d_angle = d_angle + 8'd1;
                        wrote = 1'b1;
                        if (d_angle >= cfg.open_angle) begin
                            d_open_t = it.now_ms;
                            d_mode   = DOOR_OPEN;
                        end
                    end
                end
                DOOR_OPEN: begin
                    if (ms_since(it.now_ms, d_open_t) >= cfg.hold_open_ms)
                        d_mode = DOOR_CLOSING;
                end
                default: begin
                    // presence reverses the door without a servo step
                    if (ms_since(it.now_ms, d_closing_smp_t) >= cfg.sensor_period_ms) begin
                        d_closing_smp_t = it.now_ms;
                        sampled         = 1'b1;
                        if (someone_there(it.distance_mm)) begin
                            open_door();
                            turned = 1'b1;
                        end
                    end
                    if (!turned && ms_since(it.now_ms, d_move_t) >= cfg.step_period_ms) begin
                        d_move_t = it.now_ms;
                        if (d_angle != 8'd0)
                            d_angle = d_angle - 8'd1;
                        wrote = 1'b1;
                        if (d_angle <= cfg.closed_angle) begin
                            d_attached = 1'b0;
                            d_mode     = DOOR_CLOSED;
                        end
                    end
                end
            endcase
        end
        res.door_state     = d_mode;
        res.angle_out      = d_angle;
        res.servo_enable   = d_attached;
        res.angle_written  = wrote;
        res.sensor_sampled = sampled;
        res.client_count   = d_clients;
        status_exp_q.push_back(res);
    endtask

    // input driver
    always @(posedge i_clk) begin : drive_samples
        t_pending nxt;
        if (!i_rst_n) begin
            in_ch.valid        <= 1'b0;
            in_ch.now_ms       <= '0;
            in_ch.button_level <= 1'b1;
            in_ch.distance_mm  <= '0;
            in_ch.emergency    <= 1'b0;
            in_gap             <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                advance_door('{in_ch.now_ms, in_ch.button_level, in_ch.distance_mm,
                               in_ch.emergency});
            if (!in_ch.valid || in_ch.ready) begin
                if (in_gap != 0) begin
                    in_gap      <= in_gap - 1;
                    in_ch.valid <= 1'b0;
                end else if (sample_q.size() != 0 &&
                             (!sample_q[0].drain_first || status_exp_q.size() == 0)) begin
                    nxt = sample_q.pop_front();
                    in_ch.valid        <= 1'b1;
                    in_ch.now_ms       <= nxt.smp.now_ms;
                    in_ch.button_level <= nxt.smp.button_level;
                    in_ch.distance_mm  <= nxt.smp.distance_mm;
                    in_ch.emergency    <= nxt.smp.emergency;
                    if ($urandom_range(0, 7) == 0)
                        in_calm <= !in_calm;
                    in_gap <= in_calm ? 0 : $urandom_range(0, 5);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // output monitor and checker
    always @(posedge i_clk) begin : watch_status
        t_result     want;
        int unsigned hold;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            out_wait     <= 0;
        end else begin
            hold = out_wait;
            if (out_ch.valid && out_ch.ready) begin
                if (status_exp_q.size() == 0) begin
                    report_err("unexpected transaction", out_ch.door_state, 0);
                end else begin
                    want = status_exp_q.pop_front();
                    if (out_ch.door_state !== want.door_state)
                        report_err("door_state", out_ch.door_state, want.door_state);
                    if (out_ch.angle_out !== want.angle_out)
                        report_err("angle_out", out_ch.angle_out, want.angle_out);
                    if (out_ch.servo_enable !== want.servo_enable)
                        report_err("servo_enable", out_ch.servo_enable, want.servo_enable);
                    if (out_ch.angle_written !== want.angle_written)
                        report_err("angle_written", out_ch.angle_written, want.angle_written);
                    if (out_ch.sensor_sampled !== want.sensor_sampled)
                        report_err("sensor_sampled", out_ch.sensor_sampled,
                                   want.sensor_sampled);
                    if (out_ch.client_count !== want.client_count)
                        report_err("client_count", out_ch.client_count, want.client_count);
                end
                if ($urandom_range(0, 7) == 0)
                    out_calm <= !out_calm;
                hold = out_calm ? 0 : $urandom_range(0, 5);
            end
            if (hold != 0) begin
                out_ch.ready <= 1'b0;
                out_wait     <= hold - 1;
            end else begin
                out_ch.ready <= 1'b1;
                out_wait     <= 0;
            end
        end
    end

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CLOSED_ANGLE:  cfg.closed_angle          = val[7:0];
            REG_OPEN_ANGLE:    cfg.open_angle            = val[7:0];
            REG_PRESENCE_THR:  cfg.presence_threshold_mm = val[11:0];
            REG_HOLD_OPEN:     cfg.hold_open_ms          = val[15:0];
            REG_STEP_PERIOD:   cfg.step_period_ms        = val[7:0];
            REG_SENSOR_PERIOD: cfg.sensor_period_ms      = val[9:0];
            REG_DEBOUNCE:      cfg.press_guard_ms        = val[9:0];
            default: ;
        endcase
    endtask

    task automatic push_item(input logic [31:0] now_t, input logic btn,
                             input logic [11:0] range_mm, input logic emer,
                             input logic drain);
        t_pending p;
        p.smp.now_ms       = now_t;
        p.smp.button_level = btn;
        p.smp.distance_mm  = range_mm;
        p.smp.emergency    = emer;
        p.drain_first      = drain;
        sample_q.push_back(p);
    endtask

    // random traffic: running clock, button presses, presence bursts, emergency pulses
    task automatic queue_traffic(input int n, input int unsigned tick_max);
        int unsigned roll;
        int unsigned thr;
        logic [11:0] range_mm;
        logic        emer;
        thr = cfg.presence_threshold_mm;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 2)
                g_now = $urandom();
            else if (roll < 6)
                g_now = g_now + $urandom_range(0, 70000);
            else
                g_now = g_now + $urandom_range(0, tick_max);
            if ($urandom_range(0, 99) < 15)
                g_btn = !g_btn;
            roll = $urandom_range(0, 99);
            if (roll < 55)
                range_mm = 12'd0;
            else if (roll < 70)
                range_mm = (thr > 1) ? 12'($urandom_range(1, thr - 1)) : 12'd0;
            else if (roll < 80)
                range_mm = 12'(((thr < 2) ? 0 : thr - 1) + $urandom_range(0, 2));
            else if (roll < 84)
                range_mm = 12'hFFF;
            else
                range_mm = 12'($urandom_range(0, 4095));
            if (g_emer_left != 0) begin
                emer = 1'b1;
                g_emer_left--;
            end else if ($urandom_range(0, 99) < 2) begin
                emer = 1'b1;
                g_emer_left = $urandom_range(0, 6);
            end else begin
                emer = 1'b0;
            end
            push_item(g_now, g_btn, range_mm, emer, $urandom_range(0, 199) == 0);
        end
    endtask

    task automatic wait_drained();
        while (sample_q.size() != 0 || in_ch.valid || status_exp_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_phase(input t_cfg c, input int n, input int unsigned tick_max);
        write_reg(REG_CLOSED_ANGLE,  32'(c.closed_angle));
        write_reg(REG_OPEN_ANGLE,    32'(c.open_angle));
        write_reg(REG_PRESENCE_THR,  32'(c.presence_threshold_mm));
        write_reg(REG_HOLD_OPEN,     32'(c.hold_open_ms));
        write_reg(REG_STEP_PERIOD,   32'(c.step_period_ms));
        write_reg(REG_SENSOR_PERIOD, 32'(c.sensor_period_ms));
        write_reg(REG_DEBOUNCE,      32'(c.press_guard_ms));
        queue_traffic(n, tick_max);
        wait_drained();
    endtask

    // run time limit
    initial begin
        #2_000_000;
        $display("[automatic_door_controller_unit] ERROR");
        $finish;
    end

    initial begin
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;

        // predictor at its reset state
        cfg = cfg_of(RST_CLOSED_ANGLE, RST_OPEN_ANGLE, RST_PRESENCE_THR, RST_HOLD_OPEN,
                     RST_STEP_PERIOD, RST_SENSOR_PERIOD, RST_DEBOUNCE);
        d_mode          = DOOR_CLOSED;
        d_angle         = RST_CLOSED_ANGLE;
        d_attached      = 1'b0;
        d_emer_held     = 1'b0;
        d_last_btn      = 1'b1;
        d_press_t       = '0;
        d_move_t        = '0;
        d_open_t        = '0;
        d_closed_smp_t  = '0;
        d_closing_smp_t = '0;
        d_clients       = '0;
        g_btn           = 1'b1;
        g_emer_left     = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed samples at the reset configuration
        push_item(32'd0,          1'b1, 12'd0,    1'b0, 1'b0); // sensor period not yet due
        push_item(32'd100,        1'b1, 12'd79,   1'b0, 1'b0); // presence opens a closed door
        push_item(32'd120,        1'b1, 12'd0,    1'b0, 1'b0); // first servo step
        push_item(32'd130,        1'b0, 12'd0,    1'b0, 1'b0); // press inside debounce window
        push_item(32'd140,        1'b1, 12'd0,    1'b0, 1'b0);
        push_item(32'd400,        1'b0, 12'd0,    1'b0, 1'b0); // press while opening
        push_item(32'd401,        1'b1, 12'd80,   1'b0, 1'b0); // distance at threshold
        push_item(32'd500,        1'b1, 12'd0,    1'b1, 1'b1); // emergency rising
        push_item(32'd600,        1'b0, 12'd50,   1'b1, 1'b0); // frozen, button ignored
        push_item(32'd700,        1'b1, 12'd0,    1'b0, 1'b0); // release forces closing
        push_item(32'd701,        1'b1, 12'hFFF,  1'b0, 1'b0); // max distance
        push_item(32'd1000,       1'b0, 12'd0,    1'b0, 1'b0); // press reverses closing
        push_item(32'hFFFF_FFF0,  1'b1, 12'd0,    1'b0, 1'b0);
        push_item(32'h0000_0010,  1'b1, 12'd0,    1'b0, 1'b0); // time wraps
        push_item(32'hFFFF_FFFF,  1'b1, 12'hFFF,  1'b1, 1'b0); // all ones
        push_item(32'h0000_0005,  1'b1, 12'd1,    1'b0, 1'b0); // release then presence reverse
        push_item(32'h0000_0006,  1'b0, 12'd0,    1'b0, 1'b0);
        g_now = 32'd10;
        queue_traffic(180, 60);
        wait_drained();

        // minimum, maximum, typical, inverted angles, then random settings
        run_phase(cfg_of(0, 0, 0, 0, 0, 0, 0), 180, 3);
        run_phase(cfg_of(255, 255, 4095, 65535, 255, 1023, 1023), 180, 1500);
        g_now = 32'hFFFF_F000;
        run_phase(cfg_of(30, 40, 500, 50, 5, 20, 30), 220, 25);
        run_phase(cfg_of(100, 50, 200, 20, 3, 10, 10), 150, 12);
        for (int ph = 0; ph < 3; ph++)
            run_phase(cfg_of($urandom_range(0, 180), $urandom_range(0, 180),
                             $urandom_range(0, 4095), $urandom_range(0, 2000),
                             $urandom_range(0, 40), $urandom_range(0, 300),
                             $urandom_range(0, 400)), 170, 50);

        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[automatic_door_controller_unit] OK");
        end else begin
            $display("[automatic_door_controller_unit] ERROR");
        end
        $finish;
    end

endmodule
